// ===== rtl/rcp_pkg.sv =====
// Shared types, codes and helpers for the RESP command parser.
package rcp_pkg;

  // Result kinds.
  localparam logic [1:0] EV_ARG_BYTE = 2'd0;
  localparam logic [1:0] EV_COMMAND  = 2'd1;
  localparam logic [1:0] EV_ERROR    = 2'd2;

  // Command codes.
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_GET    = 3'd1;
  localparam logic [2:0] CMD_DEL    = 3'd2;
  localparam logic [2:0] CMD_EXISTS = 3'd3;
  localparam logic [2:0] CMD_KEYS   = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PROTOCOL = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
  localparam logic [1:0] ERR_ARGCOUNT = 2'd3;

  // Longest command name that is buffered.
  localparam int NAME_MAX = 6;

  typedef logic [NAME_MAX-1:0][7:0] name_buf_t;

  // Outcome of the command name lookup.
  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] err;
  } match_t;

  // Fold a lower-case letter to upper case.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "a" && c <= "z") begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rcp_name_match.sv =====
// Case-insensitive lookup of the buffered command name.
module rcp_name_match (
  input  rcp_pkg::name_buf_t name,
  input  logic [2:0]         name_length,
  input  logic               name_too_long,
  output rcp_pkg::match_t    result
);

  logic [7:0] up [rcp_pkg::NAME_MAX];
  logic       is_set, is_get, is_del, is_exists, is_keys;

  // Fold every buffered byte; bytes beyond the name length never decide a match.
  always_comb begin
    for (int i = 0; i < rcp_pkg::NAME_MAX; i++) begin
      up[i] = rcp_pkg::to_upper(name[i]);
    end
  end

  // Parallel compare against each known name of matching length.
  assign is_set    = (name_length == 3'd3) && ({up[0], up[1], up[2]} == "SET");
  assign is_get    = (name_length == 3'd3) && ({up[0], up[1], up[2]} == "GET");
  assign is_del    = (name_length == 3'd3) && ({up[0], up[1], up[2]} == "DEL");
  assign is_keys   = (name_length == 3'd4) && ({up[0], up[1], up[2], up[3]} == "KEYS");
  assign is_exists = (name_length == 3'd6) &&
                     ({up[0], up[1], up[2], up[3], up[4], up[5]} == "EXISTS");

  // A name that overflowed the buffer is always unknown.
  always_comb begin
    result.cmd = rcp_pkg::CMD_SET;
    result.err = rcp_pkg::ERR_UNKNOWN;
    if (!name_too_long) begin
      priority if (is_set) begin
        result.err = rcp_pkg::ERR_NONE;
      end else if (is_get) begin
        result.cmd = rcp_pkg::CMD_GET;
        result.err = rcp_pkg::ERR_NONE;
      end else if (is_del) begin
        result.cmd = rcp_pkg::CMD_DEL;
        result.err = rcp_pkg::ERR_NONE;
      end else if (is_exists) begin
        result.cmd = rcp_pkg::CMD_EXISTS;
        result.err = rcp_pkg::ERR_NONE;
      end else if (is_keys) begin
        result.cmd = rcp_pkg::CMD_KEYS;
        result.err = rcp_pkg::ERR_NONE;
      end else begin
        result.err = rcp_pkg::ERR_UNKNOWN;
      end
    end
  end

endmodule

// ===== rtl/resp_command_parser_unit.sv =====
// Top level of the RESP command parser: byte stream in, argument bytes and events out.
//
// The parser takes one protocol byte per request and sustains one byte per clock
// while the output is not back-pressured. Each byte passes an input register, one
// step of the parse state machine (a digit multiply-by-ten and add, a limit compare,
// a parallel name compare) and lands in a result register. The output register is
// refilled in the cycle it is taken, and the input register takes a new byte whenever
// the parse step can advance. Key bytes (arg_index 1) and value bytes (arg_index 2)
// stream out as they arrive; after the last element a command event carries the key
// and value lengths, or an error event is emitted. Protocol errors skip input up to
// the next LF.
module resp_command_parser_unit #(
  parameter int LENGTH_BITS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [1:0] arg_index, [9:2] data_byte,
                                      // [12:10] command_type, [14:13] error_code,
                                      // [46:15] key_length, [78:47] value_length
  output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

  localparam int ACC_BITS = (LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS;

  // Parse phases.
  localparam logic [3:0] PH_STAR   = 4'd0;
  localparam logic [3:0] PH_CNT    = 4'd1;
  localparam logic [3:0] PH_CNT_LF = 4'd2;
  localparam logic [3:0] PH_DOLLAR = 4'd3;
  localparam logic [3:0] PH_LEN    = 4'd4;
  localparam logic [3:0] PH_LEN_LF = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_TRAIL  = 4'd7;
  localparam logic [3:0] PH_SKIP   = 4'd8;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Parser state.
  logic [3:0]             parse_phase, parse_phase_next;
  logic [COUNT_BITS-1:0]  tokens_left, tokens_left_next;
  logic [COUNT_BITS-1:0]  token_number, token_number_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [ACC_BITS-1:0]    number_accumulator, number_accumulator_next;
  logic                   digit_seen, digit_seen_next;
  rcp_pkg::name_buf_t     name_buffer;
  logic [2:0]             name_length, name_length_next;
  logic                   name_too_long, name_too_long_next;
  logic [2:0]             current_command, current_command_next;
  logic [1:0]             pending_error, pending_error_next;
  logic [LENGTH_BITS-1:0] saved_key_length, saved_key_length_next;
  logic [LENGTH_BITS-1:0] saved_value_length, saved_value_length_next;
  logic                   name_write;

  // Result register contents.
  logic       ev_valid;
  logic [1:0] ev_kind, ev_arg, ev_err;
  logic [7:0] ev_data;
  logic [2:0] ev_cmd;
  logic [31:0] ev_klen, ev_vlen;
  logic [1:0] out_kind, out_arg, out_err;
  logic [7:0] out_data;
  logic [2:0] out_cmd;
  logic [31:0] out_klen, out_vlen;

  logic advance, step;
  logic is_digit;
  logic [ACC_BITS+3:0] acc_times_ten;
  logic count_overflow, length_overflow;
  logic [LENGTH_BITS-1:0] bytes_dec;
  logic [COUNT_BITS-1:0] tokens_dec, token_inc;
  logic [2:0] fin_cmd;
  logic [1:0] fin_err;
  rcp_pkg::match_t lookup;

  // Handshake: the step runs when the result register is free or being drained.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  rcp_name_match u_match (
    .name          (name_buffer),
    .name_length   (name_length),
    .name_too_long (name_too_long),
    .result        (lookup)
  );

  // Digit accumulation and the two range limits.
  assign is_digit = (in_byte >= "0") && (in_byte <= "9");
  assign acc_times_ten = ({4'd0, number_accumulator} << 3) + ({4'd0, number_accumulator} << 1)
                         + (ACC_BITS+4)'(in_byte - "0");
  assign count_overflow  = |acc_times_ten[ACC_BITS+3:COUNT_BITS];
  assign length_overflow = |acc_times_ten[ACC_BITS+3:LENGTH_BITS];

  assign bytes_dec  = bytes_left - LENGTH_BITS'(1);
  assign tokens_dec = tokens_left - COUNT_BITS'(1);
  assign token_inc  = token_number + COUNT_BITS'(1);

  // The name is classified in the same step that ends the first element.
  always_comb begin
    if (token_number == '0) begin
      fin_cmd = lookup.cmd;
      fin_err = lookup.err;
    end else begin
      fin_cmd = current_command;
      fin_err = pending_error;
    end
  end

  // One parse step for the byte in the input register.
  always_comb begin
    parse_phase_next        = parse_phase;
    tokens_left_next        = tokens_left;
    token_number_next       = token_number;
    bytes_left_next         = bytes_left;
    number_accumulator_next = number_accumulator;
    digit_seen_next         = digit_seen;
    name_length_next        = name_length;
    name_too_long_next      = name_too_long;
    current_command_next    = current_command;
    pending_error_next      = pending_error;
    saved_key_length_next   = saved_key_length;
    saved_value_length_next = saved_value_length;
    name_write              = 1'b0;
    ev_valid = 1'b0;
    ev_kind  = rcp_pkg::EV_ARG_BYTE;
    ev_arg   = 2'd0;
    ev_data  = 8'd0;
    ev_cmd   = rcp_pkg::CMD_SET;
    ev_err   = rcp_pkg::ERR_NONE;
    ev_klen  = 32'd0;
    ev_vlen  = 32'd0;

    unique case (parse_phase)
      PH_STAR: begin
        if (in_byte == "*") begin
          tokens_left_next        = '0;
          token_number_next       = '0;
          number_accumulator_next = '0;
          digit_seen_next         = 1'b0;
          name_length_next        = 3'd0;
          name_too_long_next      = 1'b0;
          current_command_next    = rcp_pkg::CMD_SET;
          pending_error_next      = rcp_pkg::ERR_NONE;
          saved_key_length_next   = '0;
          saved_value_length_next = '0;
          parse_phase_next        = PH_CNT;
        end else begin
          ev_valid = 1'b1;
        end
      end
      PH_CNT, PH_LEN: begin
        if (is_digit) begin
          if ((parse_phase == PH_CNT) ? count_overflow : length_overflow) begin
            ev_valid = 1'b1;
          end else begin
            number_accumulator_next = acc_times_ten[ACC_BITS-1:0];
            digit_seen_next         = 1'b1;
          end
        end else if (in_byte == 8'h0d && digit_seen) begin
          parse_phase_next = (parse_phase == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
        end else begin
          ev_valid = 1'b1;
        end
      end
      PH_CNT_LF: begin
        if (in_byte != 8'h0a || number_accumulator == '0) begin
          ev_valid = 1'b1;
        end else begin
          tokens_left_next  = number_accumulator[COUNT_BITS-1:0];
          token_number_next = '0;
          parse_phase_next  = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (in_byte == "$") begin
          number_accumulator_next = '0;
          digit_seen_next         = 1'b0;
          parse_phase_next        = PH_LEN;
        end else begin
          ev_valid = 1'b1;
        end
      end
      PH_LEN_LF: begin
        if (in_byte != 8'h0a) begin
          ev_valid = 1'b1;
        end else begin
          if (token_number == COUNT_BITS'(1)) begin
            saved_key_length_next = number_accumulator[LENGTH_BITS-1:0];
          end else if (token_number == COUNT_BITS'(2)) begin
            saved_value_length_next = number_accumulator[LENGTH_BITS-1:0];
          end
          if (number_accumulator != '0) begin
            bytes_left_next  = number_accumulator[LENGTH_BITS-1:0];
            parse_phase_next = PH_DATA;
          end else begin
            bytes_left_next  = LENGTH_BITS'(2);
            parse_phase_next = PH_TRAIL;
          end
        end
      end
      PH_DATA: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) begin
          bytes_left_next  = LENGTH_BITS'(2);
          parse_phase_next = PH_TRAIL;
        end
        if (token_number == '0) begin
          if (name_length < 3'(rcp_pkg::NAME_MAX)) begin
            name_write       = 1'b1;
            name_length_next = name_length + 3'd1;
          end else begin
            name_too_long_next = 1'b1;
          end
        end else if (token_number == COUNT_BITS'(1) || token_number == COUNT_BITS'(2)) begin
          ev_valid = 1'b1;
          ev_kind  = rcp_pkg::EV_ARG_BYTE;
          ev_arg   = token_number[1:0];
          ev_data  = in_byte;
        end
      end
      PH_TRAIL: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) begin
          current_command_next = fin_cmd;
          pending_error_next   = fin_err;
          token_number_next    = token_inc;
          tokens_left_next     = tokens_dec;
          if (tokens_dec == '0) begin
            parse_phase_next = PH_STAR;
            ev_valid         = 1'b1;
            if (fin_err != rcp_pkg::ERR_NONE) begin
              ev_kind = rcp_pkg::EV_ERROR;
              ev_err  = fin_err;
            end else if ((fin_cmd == rcp_pkg::CMD_SET && token_inc < COUNT_BITS'(3)) ||
                         ((fin_cmd == rcp_pkg::CMD_GET || fin_cmd == rcp_pkg::CMD_DEL ||
                           fin_cmd == rcp_pkg::CMD_EXISTS) && token_inc != COUNT_BITS'(2))) begin
              ev_kind = rcp_pkg::EV_ERROR;
              ev_err  = rcp_pkg::ERR_ARGCOUNT;
              ev_cmd  = fin_cmd;
            end else begin
              ev_kind = rcp_pkg::EV_COMMAND;
              ev_cmd  = fin_cmd;
              if (fin_cmd != rcp_pkg::CMD_KEYS) begin
                ev_klen = 32'(saved_key_length);
              end
              if (fin_cmd == rcp_pkg::CMD_SET) begin
                ev_vlen = 32'(saved_value_length);
              end
            end
          end else begin
            parse_phase_next = PH_DOLLAR;
          end
        end
      end
      PH_SKIP: begin
        if (in_byte == 8'h0a) begin
          parse_phase_next = PH_STAR;
        end
      end
      default: begin
        parse_phase_next = PH_STAR;
      end
    endcase

    // Every failure above is a protocol error that abandons the command.
    if (ev_valid && parse_phase != PH_DATA && parse_phase != PH_TRAIL) begin
      ev_kind          = rcp_pkg::EV_ERROR;
      ev_err           = rcp_pkg::ERR_PROTOCOL;
      parse_phase_next = (in_byte == 8'h0a) ? PH_STAR : PH_SKIP;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_STAR;
      tokens_left        <= '0;
      token_number       <= '0;
      bytes_left         <= '0;
      number_accumulator <= '0;
      digit_seen         <= 1'b0;
      name_length        <= 3'd0;
      name_too_long      <= 1'b0;
      current_command    <= rcp_pkg::CMD_SET;
      pending_error      <= rcp_pkg::ERR_NONE;
      saved_key_length   <= '0;
      saved_value_length <= '0;
    end else if (step) begin
      parse_phase        <= parse_phase_next;
      tokens_left        <= tokens_left_next;
      token_number       <= token_number_next;
      bytes_left         <= bytes_left_next;
      number_accumulator <= number_accumulator_next;
      digit_seen         <= digit_seen_next;
      name_length        <= name_length_next;
      name_too_long      <= name_too_long_next;
      current_command    <= current_command_next;
      pending_error      <= pending_error_next;
      saved_key_length   <= saved_key_length_next;
      saved_value_length <= saved_value_length_next;
    end
  end

  // Name buffer: each entry is written only when the fill position reaches it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < rcp_pkg::NAME_MAX; i++) begin
      if (step && name_write && name_length == 3'(i)) begin
        name_buffer[i] <= in_byte;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= step && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ev_valid) begin
      out_kind <= ev_kind;
      out_arg  <= ev_arg;
      out_data <= ev_data;
      out_cmd  <= ev_cmd;
      out_err  <= ev_err;
      out_klen <= ev_klen;
      out_vlen <= ev_vlen;
    end
  end

  assign m_axis_tdata = {1'b0, out_vlen, out_klen, out_err, out_cmd, out_data, out_arg};
  assign m_axis_tuser = out_kind;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the RESP command parser with a built-in predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        RANDOM_BYTES = 640;
  localparam int        CYCLE_LIMIT  = 200000;
  localparam int        DRAIN_CYCLES = 20;
  localparam logic [7:0] CR          = 8'h0D;
  localparam logic [7:0] LF          = 8'h0A;
  localparam logic [63:0] COUNT_CEILING  = 64'hFFFF;
  localparam logic [63:0] LENGTH_CEILING = 64'hFFFF_FFFF;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    PH_ARRAY, PH_COUNT, PH_COUNT_LF, PH_MARKER, PH_LENGTH,
    PH_LENGTH_LF, PH_PAYLOAD, PH_TRAILER, PH_RESYNC
  } parse_phase_t;

  // One result of the parser.
  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  arg;
    logic [7:0]  data;
    logic [2:0]  cmd;
    logic [1:0]  err;
    logic [31:0] key_len;
    logic [31:0] value_len;
  } parser_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic [7:0]    stream_bytes [$];
  parser_event_t expected_events [$];
  int            accepted_bytes = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  logic          quiet_stretch;

  string      command_text [5] = '{"SET", "GET", "DEL", "EXISTS", "KEYS"};
  logic [2:0] command_code [5] = '{rcp_pkg::CMD_SET, rcp_pkg::CMD_GET, rcp_pkg::CMD_DEL,
                                   rcp_pkg::CMD_EXISTS, rcp_pkg::CMD_KEYS};

  // Predictor state.
  parse_phase_t phase = PH_ARRAY;
  logic [15:0]  tokens_left = '0;
  logic [15:0]  token_num = '0;
  logic [31:0]  bytes_left = '0;
  logic [31:0]  number_acc = '0;
  logic         digit_seen = 1'b0;
  logic [7:0]   name_buf [rcp_pkg::NAME_MAX];
  int           name_len = 0;
  logic         name_long = 1'b0;
  logic [2:0]   cur_cmd = rcp_pkg::CMD_SET;
  logic [1:0]   pend_err = rcp_pkg::ERR_NONE;
  logic [31:0]  key_len = '0;
  logic [31:0]  value_len = '0;

  resp_command_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Both sides run without idling through a stretch in the middle of the run.
  assign quiet_stretch = (accepted_bytes >= 400) && (accepted_bytes < 700);

  // Append one byte to the pending request stream.
  task automatic append_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endtask

  task automatic push_event(input logic [1:0] kind, input logic [1:0] arg,
                            input logic [7:0] data, input logic [2:0] cmd,
                            input logic [1:0] err, input logic [31:0] klen,
                            input logic [31:0] vlen);
    parser_event_t ev;
    ev.kind      = kind;
    ev.arg       = arg;
    ev.data      = data;
    ev.cmd       = cmd;
    ev.err       = err;
    ev.key_len   = klen;
    ev.value_len = vlen;
    expected_events.insert(expected_events.size(), ev);
  endtask

  // A protocol error abandons the command; an offending LF resumes parsing at once.
  task automatic flag_protocol_error(input logic [7:0] b);
    phase = (b == LF) ? PH_ARRAY : PH_RESYNC;
    push_event(rcp_pkg::EV_ERROR, 2'd0, 8'd0, rcp_pkg::CMD_SET, rcp_pkg::ERR_PROTOCOL,
               '0, '0);
  endtask

  // Advance the predictor by one accepted byte.
  task automatic parse_byte(input logic [7:0] b);
    logic        is_digit;
    logic        same;
    logic [7:0]  folded;
    logic [63:0] grown;
    logic [63:0] ceiling;
    is_digit = (b >= "0") && (b <= "9");
    case (phase)
      PH_ARRAY: begin
        if (b != "*") begin
          flag_protocol_error(b);
        end else begin
          tokens_left = '0;
          token_num   = '0;
          number_acc  = '0;
          digit_seen  = 1'b0;
          name_len    = 0;
          name_long   = 1'b0;
          cur_cmd     = rcp_pkg::CMD_SET;
          pend_err    = rcp_pkg::ERR_NONE;
          key_len     = '0;
          value_len   = '0;
          phase       = PH_COUNT;
        end
      end
      PH_COUNT, PH_LENGTH: begin
        if (is_digit) begin
          ceiling = (phase == PH_COUNT) ? COUNT_CEILING : LENGTH_CEILING;
          grown   = number_acc;
          grown   = grown * 64'd10 + (b - 8'h30);
          if (grown > ceiling) begin
            flag_protocol_error(b);
          end else begin
            number_acc = grown[31:0];
            digit_seen = 1'b1;
          end
        end else if (b == CR && digit_seen) begin
          phase = (phase == PH_COUNT) ? PH_COUNT_LF : PH_LENGTH_LF;
        end else begin
          flag_protocol_error(b);
        end
      end
      PH_COUNT_LF: begin
        if (b != LF || number_acc == 0) begin
          flag_protocol_error(b);
        end else begin
          tokens_left = number_acc[15:0];
          token_num   = '0;
          phase       = PH_MARKER;
        end
      end
      PH_MARKER: begin
        if (b != "$") begin
          flag_protocol_error(b);
        end else begin
          number_acc = '0;
          digit_seen = 1'b0;
          phase      = PH_LENGTH;
        end
      end
      PH_LENGTH_LF: begin
        if (b != LF) begin
          flag_protocol_error(b);
        end else begin
          if (token_num == 1) begin
            key_len = number_acc;
          end else if (token_num == 2) begin
            value_len = number_acc;
          end
          if (number_acc != 0) begin
            bytes_left = number_acc;
            phase      = PH_PAYLOAD;
          end else begin
            bytes_left = 2;
            phase      = PH_TRAILER;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          bytes_left = 2;
          phase      = PH_TRAILER;
        end
        // The first element is the command name; elements 1 and 2 stream out.
        if (token_num == 0) begin
          if (name_len < rcp_pkg::NAME_MAX) begin
            name_buf[name_len] = b;
            name_len++;
          end else begin
            name_long = 1'b1;
          end
        end else if (token_num == 1 || token_num == 2) begin
          push_event(rcp_pkg::EV_ARG_BYTE, token_num[1:0], b, rcp_pkg::CMD_SET,
                     rcp_pkg::ERR_NONE, '0, '0);
        end
      end
      PH_TRAILER: begin
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          // Name lookup without regard to case, once the name element is done.
          if (token_num == 0) begin
            pend_err = rcp_pkg::ERR_UNKNOWN;
            cur_cmd  = rcp_pkg::CMD_SET;
            if (!name_long) begin
              for (int k = 0; k < 5; k++) begin
                same = (name_len == command_text[k].len());
                for (int i = 0; same && i < name_len; i++) begin
                  folded = name_buf[i];
                  if (folded >= "a" && folded <= "z") begin
                    folded = folded - 8'd32;
                  end
                  if (folded != command_text[k][i]) begin
                    same = 1'b0;
                  end
                end
                if (same && pend_err != rcp_pkg::ERR_NONE) begin
                  cur_cmd  = command_code[k];
                  pend_err = rcp_pkg::ERR_NONE;
                end
              end
            end
          end
          token_num   = token_num + 16'd1;
          tokens_left = tokens_left - 16'd1;
          if (tokens_left == 0) begin
            phase = PH_ARRAY;
            // Closing event with the argument count check.
            if (pend_err != rcp_pkg::ERR_NONE) begin
              push_event(rcp_pkg::EV_ERROR, 2'd0, 8'd0, rcp_pkg::CMD_SET, pend_err, '0, '0);
            end else if ((cur_cmd == rcp_pkg::CMD_SET && token_num < 3) ||
                         ((cur_cmd == rcp_pkg::CMD_GET || cur_cmd == rcp_pkg::CMD_DEL ||
                           cur_cmd == rcp_pkg::CMD_EXISTS) && token_num != 2)) begin
              push_event(rcp_pkg::EV_ERROR, 2'd0, 8'd0, cur_cmd, rcp_pkg::ERR_ARGCOUNT,
                         '0, '0);
            end else begin
              push_event(rcp_pkg::EV_COMMAND, 2'd0, 8'd0, cur_cmd, rcp_pkg::ERR_NONE,
                         (cur_cmd != rcp_pkg::CMD_KEYS) ? key_len : 32'd0,
                         (cur_cmd == rcp_pkg::CMD_SET) ? value_len : 32'd0);
            end
          end else begin
            phase = PH_MARKER;
          end
        end
      end
      PH_RESYNC: begin
        if (b == LF) begin
          phase = PH_ARRAY;
        end
      end
      default: begin
        phase = PH_ARRAY;
      end
    endcase
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", label, want, got);
      mismatch_count++;
    end
  endtask

  // Compare one accepted result with the oldest expected event.
  task automatic check_event();
    parser_event_t want;
    if (expected_events.size() == 0) begin
      $error("event_kind: expected no result, actual %0d", m_axis_tuser);
      mismatch_count++;
    end else begin
      want = expected_events.pop_front();
      compare_field("event_kind", want.kind, m_axis_tuser);
      compare_field("arg_index", want.arg, m_axis_tdata[1:0]);
      compare_field("data_byte", want.data, m_axis_tdata[9:2]);
      compare_field("command_type", want.cmd, m_axis_tdata[12:10]);
      compare_field("error_code", want.err, m_axis_tdata[14:13]);
      compare_field("key_length", want.key_len, m_axis_tdata[46:15]);
      compare_field("value_length", want.value_len, m_axis_tdata[78:47]);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_byte(s[i]);
    end
  endtask

  task automatic put_header(input int count);
    put_text($sformatf("*%0d\015\n", count));
  endtask

  task automatic put_bulk_text(input string s);
    put_text($sformatf("$%0d\015\n", s.len()));
    put_text(s);
    put_text("\015\n");
  endtask

  // Element of random bytes; the unchecked trailer is sometimes garbage.
  task automatic put_bulk_random(input int len);
    put_text($sformatf("$%0d\015\n", len));
    repeat (len) append_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 85) begin
      put_text("\015\n");
    end else begin
      append_byte(8'($urandom_range(255)));
      append_byte(8'($urandom_range(255)));
    end
  endtask

  // A well-formed command, usually with a plausible argument count.
  task automatic add_random_command();
    int    k;
    int    elements;
    string word;
    k = $urandom_range(4);
    if ($urandom_range(99) < 12) begin
      elements = $urandom_range(4, 1);
      put_header(elements);
      put_bulk_random($urandom_range(8));
    end else begin
      if ($urandom_range(99) < 70) begin
        elements = (k == 0) ? 3 : (k == 4) ? $urandom_range(3, 1) : 2;
      end else begin
        elements = $urandom_range(5, 1);
      end
      word = command_text[k];
      for (int i = 0; i < word.len(); i++) begin
        if ($urandom_range(1)) begin
          word[i] = word[i] + 8'd32;
        end
      end
      put_header(elements);
      put_bulk_text(word);
    end
    for (int e = 1; e < elements; e++) begin
      put_bulk_random(($urandom_range(99) < 5) ? $urandom_range(60, 20) : $urandom_range(10));
    end
  endtask

  // Request driver: takes the next byte when the current one has been accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stream_bytes.size() > 0 && (quiet_stretch || $urandom_range(99) >= 6)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stream_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts from accepted requests and checks accepted results.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_stretch || ($urandom_range(99) >= 6);
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata);
        accepted_bytes <= accepted_bytes + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_event();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("resp_command_parser_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int roll;
    int start;
    int random_end;

    // Directed commands: every command, mixed case, argument count cases.
    put_header(3); put_bulk_text("SET"); put_bulk_text("key"); put_bulk_text("value");
    put_header(2); put_bulk_text("get"); put_bulk_text("abc");
    put_header(2); put_bulk_text("Del"); put_bulk_text("k1");
    put_header(2); put_bulk_text("ExIsTs"); put_bulk_text("x");
    put_header(2); put_bulk_text("keys"); put_bulk_text("*");
    put_header(1); put_bulk_text("KEYS");
    put_header(4); put_bulk_text("set"); put_bulk_text("k"); put_bulk_text("v");
    put_bulk_text("extra");
    put_header(3); put_bulk_text("GET"); put_bulk_text("a"); put_bulk_text("b");
    put_header(2); put_bulk_text("SET"); put_bulk_text("k");
    put_header(1); put_bulk_text("DEL");
    put_header(3); put_bulk_text("SET"); put_bulk_text(""); put_bulk_text("");
    // Unknown, overlong and empty names.
    put_header(2); put_bulk_text("PING"); put_bulk_text("x");
    put_header(2); put_bulk_text("EXISTSX"); put_bulk_text("x");
    put_header(1); put_bulk_text("");
    // Leading zeros, and trailer bytes that are not CR LF.
    put_text("*02\015\n$0003\015\nGET\015\n$1\015\nq\015\n");
    put_text("*2\015\n$3\015\nGETxx$1\015\nkAB");
    // Key bytes at both extremes.
    put_header(3); put_bulk_text("SET");
    put_text("$2\015\n");
    append_byte(8'h00);
    append_byte(8'hFF);
    put_text("\015\n");
    put_bulk_text("v");
    // Protocol errors: bad markers, bad numbers, missing LF, and LF as the bad byte.
    put_text("X*1\015\n");
    put_text("*2\015\n#3\015\n");
    put_text("*a\015\n");
    put_text("*2\015\n$-1\015\n");
    put_text("*\015\n");
    put_text("*0\015\n");
    put_text("*65536\015\n");
    put_text("*1\015\n$4294967296\015\n");
    put_text("*1\015X\n");
    put_text("*1\n");
    put_header(2); put_bulk_text("GET"); put_bulk_text("z");

    // Random part: mostly well-formed commands, some corrupted, some noise.
    random_end = stream_bytes.size() + RANDOM_BYTES;
    while (stream_bytes.size() < random_end) begin
      roll  = $urandom_range(99);
      start = stream_bytes.size();
      if (roll < 8) begin
        repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
        append_byte(LF);
      end else begin
        add_random_command();
        if (roll < 18) begin
          stream_bytes[$urandom_range(stream_bytes.size() - 1, start)] =
            8'($urandom_range(255));
        end
      end
    end

    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for all requests and all results, then let the pipeline drain.
    while (stream_bytes.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (expected_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("resp_command_parser_unit regression: pass");
    end else begin
      $display("resp_command_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== resp_command_parser_unit.f =====
rtl/rcp_pkg.sv
rtl/rcp_name_match.sv
rtl/resp_command_parser_unit.sv
verif/tb_top.sv
